// ===== sv/utf8nv_pkg.sv =====
package utf8nv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [CountW-1:0] MinCharsReset = 8'd2;
  localparam logic [CountW-1:0] MaxCharsReset = 8'd127;
  localparam logic [CountW-1:0] CountMax      = 8'd255;

  localparam logic [CodeW-1:0] LowestTwo   = 21'h000080;
  localparam logic [CodeW-1:0] LowestThree = 21'h000800;
  localparam logic [CodeW-1:0] LowestFour  = 21'h010000;
  localparam logic [CodeW-1:0] CodeMax     = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrLow     = 21'h00D800;
  localparam logic [CodeW-1:0] SurrHigh    = 21'h00DFFF;

  // Sequence length class of the sequence being assembled
  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  // Configuration register indexes
  localparam logic CfgMinChars = 1'b0;
  localparam logic CfgMaxChars = 1'b1;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrUtf8   = 2'd1,
    ErrLength = 2'd2,
    ErrChar   = 2'd3
  } err_e;

  typedef struct packed {
    logic [ByteW-1:0] name_byte;
    logic             carries_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] char_count;
    err_e              error_code;
    logic              name_ok;
  } verdict_t;

  function automatic logic in_allowed_set(input logic [CodeW-1:0] c);
    logic ok;
    ok = 1'b0;
    if (c >= 21'h41 && c <= 21'h5A) ok = 1'b1;
    if (c >= 21'h61 && c <= 21'h7A) ok = 1'b1;
    if (c >= 21'h30 && c <= 21'h39) ok = 1'b1;
    if (c == 21'h5F || c == 21'h2D) ok = 1'b1;
    if (c >= 21'h410 && c <= 21'h44F) ok = 1'b1;
    if (c == 21'h401 || c == 21'h451) ok = 1'b1;
    return ok;
  endfunction

endpackage

// ===== sv/utf8nv_in_reg.sv =====
module utf8nv_in_reg
  import utf8nv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_item_t s_item_i,
  input  logic     go_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign s_ready_o = !valid_q || go_i;
  assign load      = s_valid_i && s_ready_o;
  assign valid_d   = load || (valid_q && !go_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/utf8nv_decode.sv =====
module utf8nv_decode
  import utf8nv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  in_item_t          item_i,
  input  logic [CountW-1:0] min_chars_i,
  input  logic [CountW-1:0] max_chars_i,
  output verdict_t          verdict_o
);

  logic [CodeW-1:0]  acc_q, acc_d;
  logic [1:0]        pend_q, pend_d;
  logic [1:0]        cls_q, cls_d;
  logic [CountW-1:0] chars_q, chars_d;
  logic              utf8_bad_q, utf8_bad_d;
  logic              char_bad_q, char_bad_d;

  logic [ByteW-1:0]  b;
  logic [CodeW-1:0]  acc_next;
  logic [CodeW-1:0]  lowest;
  logic [CodeW-1:0]  ch;
  logic              take;
  logic              bad;
  logic              final_bad;
  err_e              err;

  assign b        = item_i.name_byte;
  assign acc_next = {acc_q[CodeW-7:0], b[5:0]};

  always_comb begin
    case (cls_q)
      SeqTwo:   lowest = LowestTwo;
      SeqThree: lowest = LowestThree;
      default:  lowest = LowestFour;
    endcase
  end

  always_comb begin
    acc_d      = acc_q;
    pend_d     = pend_q;
    cls_d      = cls_q;
    chars_d    = chars_q;
    utf8_bad_d = utf8_bad_q;
    char_bad_d = char_bad_q;
    take       = 1'b0;
    bad        = 1'b0;
    ch         = {{(CodeW-ByteW){1'b0}}, b};

    if (go_i && item_i.carries_byte && !utf8_bad_q) begin
      if (pend_q == 2'd0) begin
        if (!b[7]) begin
          take = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {{(CodeW-5){1'b0}}, b[4:0]};
          pend_d = 2'd1;
          cls_d  = SeqTwo;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {{(CodeW-4){1'b0}}, b[3:0]};
          pend_d = 2'd2;
          cls_d  = SeqThree;
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {{(CodeW-3){1'b0}}, b[2:0]};
          pend_d = 2'd3;
          cls_d  = SeqFour;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        acc_d  = acc_next;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          // sequence complete: check range and hand the character on
          ch     = acc_next;
          acc_d  = '0;
          cls_d  = SeqNone;
          if (acc_next < lowest || acc_next > CodeMax ||
              (acc_next >= SurrLow && acc_next <= SurrHigh)) begin
            bad = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      end
    end

    if (bad) begin
      utf8_bad_d = 1'b1;
      pend_d     = 2'd0;
      cls_d      = SeqNone;
      acc_d      = '0;
    end

    if (take) begin
      if (chars_q != CountMax) chars_d = chars_q + 8'd1;
      if (!in_allowed_set(ch)) char_bad_d = 1'b1;
    end

    final_bad = utf8_bad_d || (pend_d != 2'd0);
    if (final_bad) begin
      err = ErrUtf8;
    end else if (chars_d < min_chars_i || chars_d > max_chars_i) begin
      err = ErrLength;
    end else if (char_bad_d) begin
      err = ErrChar;
    end else begin
      err = ErrNone;
    end

    verdict_o.name_ok    = (err == ErrNone);
    verdict_o.error_code = err;
    verdict_o.char_count = chars_d;

    // clear per-name state once the verdict is out
    if (go_i && item_i.last_byte) begin
      acc_d      = '0;
      pend_d     = 2'd0;
      cls_d      = SeqNone;
      chars_d    = '0;
      utf8_bad_d = 1'b0;
      char_bad_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      pend_q     <= 2'd0;
      cls_q      <= SeqNone;
      chars_q    <= '0;
      utf8_bad_q <= 1'b0;
      char_bad_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      pend_q     <= pend_d;
      cls_q      <= cls_d;
      chars_q    <= chars_d;
      utf8_bad_q <= utf8_bad_d;
      char_bad_q <= char_bad_d;
    end
  end

endmodule

// ===== sv/utf8nv_out_reg.sv =====
module utf8nv_out_reg
  import utf8nv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  verdict_t verdict_i,
  output logic     free_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output verdict_t verdict_o
);

  logic     valid_q, valid_d;
  verdict_t verdict_q;

  assign free_o  = !valid_q || m_ready_i;
  assign valid_d = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign m_valid_o = valid_q;
  assign verdict_o = verdict_q;

endmodule

// ===== sv/utf8_name_validator_core.sv =====
// A last item's verdict is registered in the output stage when it leaves the input stage.
// Throughput: one input item per clock unless stalled; the decode state updates with each item.
// The input register stalls only when a last item meets a result the sink has not taken.
// Reset clears all per-name state and both stages; min_chars resets to 2, max_chars to 127.
module utf8_name_validator_core
  import utf8nv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] name_byte
  input  logic                s_axis_tuser,   // [0] carries_byte
  input  logic                s_axis_tlast,   // last_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] name_ok, [2:1] error_code,
                                              // [10:3] char_count, [15:11] zero
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CountW-1:0]   cfg_wdata_i
);

  logic [CountW-1:0] min_chars_q, max_chars_q;
  in_item_t          s_item, item;
  logic              item_valid;
  logic              out_free;
  logic              go;
  verdict_t          verdict, verdict_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_chars_q <= MinCharsReset;
      max_chars_q <= MaxCharsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinChars: min_chars_q <= cfg_wdata_i;
        CfgMaxChars: max_chars_q <= cfg_wdata_i;
        default:     min_chars_q <= min_chars_q;
      endcase
    end
  end

  assign s_item.name_byte    = s_axis_tdata;
  assign s_item.carries_byte = s_axis_tuser;
  assign s_item.last_byte    = s_axis_tlast;

  // advance unless a verdict would overrun a waiting result
  assign go = item_valid && (!item.last_byte || out_free);

  utf8nv_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .go_i      (go),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  utf8nv_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .item_i      (item),
    .min_chars_i (min_chars_q),
    .max_chars_i (max_chars_q),
    .verdict_o   (verdict)
  );

  utf8nv_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (go && item.last_byte),
    .verdict_i (verdict),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .verdict_o (verdict_out)
  );

  assign m_axis_tdata = {{(OutDataW-CountW-3){1'b0}}, verdict_out.char_count,
                         verdict_out.error_code, verdict_out.name_ok};

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (verdict_out.name_ok == (verdict_out.error_code == ErrNone)))
    else $error("name_ok disagrees with error_code");

  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && item.last_byte && verdict.name_ok) |->
      (verdict.char_count >= min_chars_q && verdict.char_count <= max_chars_q))
    else $error("accepted name has a count out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (item_valid && item.last_byte && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && item.last_byte) |=> m_axis_tvalid)
    else $error("verdict lost after last item");

endmodule
